/* sv/mtep_pkg.sv */
// Shared types and constants for the MIDI track event parser.
// No dependencies; every other file refers to this package by scoped names.
package mtep_pkg;

  localparam int TRACKS = 16;
  localparam int TRACK_W = 4;
  localparam int IDX_W = $clog2(TRACKS);

  localparam logic [7:0] BYTE_META = 8'hFF;
  localparam logic [7:0] BYTE_SYSEX = 8'hF0;
  localparam logic [7:0] BYTE_ESCAPE = 8'hF7;
  localparam logic [7:0] META_EOT = 8'h2F;
  localparam logic [7:0] META_TEMPO = 8'h51;
  localparam logic [3:0] HI_PROGRAM = 4'hC;
  localparam logic [3:0] HI_PRESSURE = 4'hD;
  localparam logic [3:0] HI_SYSTEM = 4'hF;

  typedef enum logic [3:0] {
    PH_DELTA     = 4'd0,
    PH_STATUS    = 4'd1,
    PH_DATA1     = 4'd2,
    PH_DATA2     = 4'd3,
    PH_META_TYPE = 4'd4,
    PH_META_LEN  = 4'd5,
    PH_TEMPO     = 4'd6,
    PH_SKIP      = 4'd7,
    PH_SYSEX_LEN = 4'd8
  } phase_t;

  typedef enum logic [1:0] {
    EV_SHORT = 2'd0,
    EV_TEMPO = 2'd1,
    EV_END   = 2'd2
  } kind_t;

  typedef struct packed {
    phase_t      phase;
    logic [7:0]  run_status;
    logic [31:0] tick_time;
    logic [31:0] delta_acc;
    logic [7:0]  first_data;
    logic [7:0]  meta_kind;
    logic [31:0] skip_count;
    logic [23:0] tempo_acc;
    logic        ended;
  } track_state_t;

  localparam track_state_t TRACK_CLEAR = '{
    phase: PH_DELTA, run_status: 8'd0, tick_time: 32'd0, delta_acc: 32'd0,
    first_data: 8'd0, meta_kind: 8'd0, skip_count: 32'd0, tempo_acc: 24'd0,
    ended: 1'b0
  };

  typedef struct packed {
    logic        emit;
    kind_t       kind;
    logic [23:0] payload;
    logic [31:0] tick_time;
  } dec_result_t;

endpackage

/* sv/mtep_track_state.sv */
// Per-track parser state held in flip-flops, one read and one write port.
// Depends on mtep_pkg for the state record and the track count.
module mtep_track_state (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [mtep_pkg::IDX_W-1:0]      rd_idx,
  output mtep_pkg::track_state_t          rd_state,
  input  logic                            wr_en,
  input  logic [mtep_pkg::IDX_W-1:0]      wr_idx,
  input  mtep_pkg::track_state_t          wr_state
);

  mtep_pkg::track_state_t state_r [mtep_pkg::TRACKS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < mtep_pkg::TRACKS; i++) begin
        state_r[i] <= mtep_pkg::TRACK_CLEAR;
      end
    end else if (wr_en) begin
      state_r[wr_idx] <= wr_state;
    end
  end

  assign rd_state = state_r[rd_idx];

endmodule

/* sv/mtep_decode.sv */
// Byte decoder: next track state and the optional event for one byte.
// Purely combinational; depends on mtep_pkg for types and byte codes.
module mtep_decode (
  input  mtep_pkg::track_state_t cur,
  input  logic [7:0]             data_byte,
  input  logic                   track_start,
  output mtep_pkg::track_state_t nxt,
  output mtep_pkg::dec_result_t  res
);

  mtep_pkg::track_state_t s;
  logic [31:0] delta_new;
  logic [31:0] skip_new;
  logic [31:0] skip_dec;
  logic        one_data;
  logic        take_first;

  always_comb begin
    s = track_start ? mtep_pkg::TRACK_CLEAR : cur;
    nxt = s;
    res.emit = 1'b0;
    res.kind = mtep_pkg::EV_SHORT;
    res.payload = 24'd0;
    res.tick_time = s.tick_time;
    delta_new = {s.delta_acc[24:0], data_byte[6:0]};
    skip_new = {s.skip_count[24:0], data_byte[6:0]};
    skip_dec = s.skip_count - 32'd1;
    one_data = s.run_status[7:4] inside {mtep_pkg::HI_PROGRAM, mtep_pkg::HI_PRESSURE};
    take_first = 1'b0;
    if (!s.ended) begin
      case (s.phase)
        mtep_pkg::PH_DELTA: begin
          nxt.delta_acc = delta_new;
          if (!data_byte[7]) begin
            nxt.tick_time = s.tick_time + delta_new;
            nxt.delta_acc = 32'd0;
            nxt.phase = mtep_pkg::PH_STATUS;
          end
        end
        mtep_pkg::PH_STATUS: begin
          if (!data_byte[7]) begin
            take_first = 1'b1;
          end else if (data_byte == mtep_pkg::BYTE_META) begin
            nxt.phase = mtep_pkg::PH_META_TYPE;
          end else if (data_byte inside {mtep_pkg::BYTE_SYSEX, mtep_pkg::BYTE_ESCAPE}) begin
            nxt.skip_count = 32'd0;
            nxt.phase = mtep_pkg::PH_SYSEX_LEN;
          end else if (data_byte[7:4] == mtep_pkg::HI_SYSTEM) begin
            nxt.phase = mtep_pkg::PH_DELTA;
          end else begin
            nxt.run_status = data_byte;
            nxt.phase = mtep_pkg::PH_DATA1;
          end
        end
        mtep_pkg::PH_DATA1: begin
          take_first = 1'b1;
        end
        mtep_pkg::PH_DATA2: begin
          nxt.phase = mtep_pkg::PH_DELTA;
          res.emit = 1'b1;
          res.payload = {data_byte, s.first_data, s.run_status};
        end
        mtep_pkg::PH_META_TYPE: begin
          nxt.meta_kind = data_byte;
          if (data_byte == mtep_pkg::META_EOT) begin
            nxt.ended = 1'b1;
            nxt.phase = mtep_pkg::PH_DELTA;
            res.emit = 1'b1;
            res.kind = mtep_pkg::EV_END;
          end else begin
            nxt.phase = mtep_pkg::PH_META_LEN;
          end
        end
        mtep_pkg::PH_META_LEN: begin
          nxt.skip_count = {24'd0, data_byte};
          if (s.meta_kind == mtep_pkg::META_TEMPO) begin
            nxt.tempo_acc = 24'd0;
            if (data_byte == 8'd0) begin
              nxt.phase = mtep_pkg::PH_DELTA;
              res.emit = 1'b1;
              res.kind = mtep_pkg::EV_TEMPO;
            end else begin
              nxt.phase = mtep_pkg::PH_TEMPO;
            end
          end else begin
            nxt.phase = (data_byte == 8'd0) ? mtep_pkg::PH_DELTA : mtep_pkg::PH_SKIP;
          end
        end
        mtep_pkg::PH_TEMPO: begin
          nxt.tempo_acc = {s.tempo_acc[15:0], data_byte};
          nxt.skip_count = skip_dec;
          if (skip_dec == 32'd0) begin
            nxt.phase = mtep_pkg::PH_DELTA;
            res.emit = 1'b1;
            res.kind = mtep_pkg::EV_TEMPO;
            res.payload = {s.tempo_acc[15:0], data_byte};
          end
        end
        mtep_pkg::PH_SKIP: begin
          nxt.skip_count = skip_dec;
          if (skip_dec == 32'd0) begin
            nxt.phase = mtep_pkg::PH_DELTA;
          end
        end
        mtep_pkg::PH_SYSEX_LEN: begin
          nxt.skip_count = skip_new;
          if (!data_byte[7]) begin
            nxt.phase = (skip_new == 32'd0) ? mtep_pkg::PH_DELTA : mtep_pkg::PH_SKIP;
          end
        end
        default: begin
          nxt.phase = mtep_pkg::PH_DELTA;
        end
      endcase
      if (take_first) begin
        if (one_data) begin
          nxt.phase = mtep_pkg::PH_DELTA;
          res.emit = 1'b1;
          res.payload = {8'd0, data_byte, s.run_status};
        end else begin
          nxt.first_data = data_byte;
          nxt.phase = mtep_pkg::PH_DATA2;
        end
      end
    end
  end

endmodule

/* sv/midi_track_event_parser.sv */
// MIDI track event parser: one beat is one byte of one track's chunk body.
// An accepted byte is registered, decoded, and its result is registered again.
// Throughput: one byte per cycle while results are not stalled, bytes of the
// same track back to back included, as track state is read and rewritten each cycle.
// Reset clears the input and result valid flags and all track state at once.
module midi_track_event_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [3:0]  in_track_index,
  input  logic [7:0]  in_data_byte,
  input  logic        in_track_start,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_event_kind,
  output logic [3:0]  out_source_track,
  output logic [31:0] out_event_time,
  output logic [31:0] out_event_word
);

  logic        in_v_r, in_v_nxt;
  logic [3:0]  trk_r;
  logic [7:0]  byte_r;
  logic        start_r;
  logic        out_v_r, out_v_nxt;
  logic [1:0]  kind_r;
  logic [3:0]  src_r;
  logic [31:0] time_r;
  logic [31:0] word_r;

  logic out_free;
  logic fire;
  logic in_range;
  logic wr_en;
  mtep_pkg::track_state_t cur_state;
  mtep_pkg::track_state_t nxt_state;
  mtep_pkg::dec_result_t  dec;

  assign out_free = !out_v_r || out_ready;
  assign fire     = in_v_r && out_free;
  assign in_ready = !in_v_r || out_free;
  assign in_range = int'(trk_r) < mtep_pkg::TRACKS;
  assign wr_en    = fire && in_range;

  mtep_track_state u_state (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_idx   (trk_r[mtep_pkg::IDX_W-1:0]),
    .rd_state (cur_state),
    .wr_en    (wr_en),
    .wr_idx   (trk_r[mtep_pkg::IDX_W-1:0]),
    .wr_state (nxt_state)
  );

  mtep_decode u_decode (
    .cur         (cur_state),
    .data_byte   (byte_r),
    .track_start (start_r),
    .nxt         (nxt_state),
    .res         (dec)
  );

  always_comb begin
    in_v_nxt = in_v_r;
    if (in_valid && in_ready) begin
      in_v_nxt = 1'b1;
    end else if (fire) begin
      in_v_nxt = 1'b0;
    end
    out_v_nxt = out_v_r;
    if (wr_en && dec.emit) begin
      out_v_nxt = 1'b1;
    end else if (out_ready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      in_v_r  <= in_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      trk_r   <= in_track_index;
      byte_r  <= in_data_byte;
      start_r <= in_track_start;
    end
    if (wr_en && dec.emit) begin
      kind_r <= dec.kind;
      src_r  <= trk_r;
      time_r <= dec.tick_time;
      word_r <= {6'd0, dec.kind, dec.payload};
    end
  end

  assign out_valid        = out_v_r;
  assign out_event_kind   = kind_r;
  assign out_source_track = src_r;
  assign out_event_time   = time_r;
  assign out_event_word   = word_r;

endmodule

/* sv/mtep_checker.sv */
// Port-level checks for the MIDI track event parser, bound to the top level.
// Depends on mtep_pkg for the event kind codes.
module mtep_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [3:0]  in_track_index,
  input logic [7:0]  in_data_byte,
  input logic        in_track_start,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_event_kind,
  input logic [3:0]  out_source_track,
  input logic [31:0] out_event_time,
  input logic [31:0] out_event_word
);

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_track_index)
      && $stable(in_data_byte) && $stable(in_track_start))
    else $error("Input beat changed while stalled.");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_event_word)
      && $stable(out_event_time) && $stable(out_source_track) && $stable(out_event_kind))
    else $error("Result beat changed while stalled.");

  a_kind_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_event_word[31:24] == {6'd0, out_event_kind}
      && out_event_kind != 2'd3)
    else $error("Event word carries a wrong kind code.");

  a_end_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_kind == mtep_pkg::EV_END |-> out_event_word[23:0] == 24'd0)
    else $error("End of track event has a non-zero body.");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("Result valid after reset.");

endmodule

bind midi_track_event_parser mtep_checker u_mtep_checker (.*);
